[design/lsf_pkg.sv]
// Shared constants and types of the Laplacian stencil filter.
`default_nettype none

package lsf_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int VALUE_BITS  = 8;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;

    localparam int COL_BITS    = 11;
    localparam int ROW_BITS    = 12;
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int GAIN_BITS   = 16;
    localparam int FRAC_BITS   = 8;

    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int ENTRY_BITS  = 2 * PIXEL_BITS;
    localparam int LAP_BITS    = PIXEL_BITS + 3;
    localparam int PROD_BITS   = GAIN_BITS + LAP_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;

    localparam int MID_LEVEL   = 128;
    localparam int ROUND_OFS   = MID_LEVEL * (1 << FRAC_BITS) + (1 << (FRAC_BITS - 1));

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd256;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_IDX_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_PTR_BITS = FIFO_IDX_BITS + 1;

    localparam int NUM_ITEMS   = 3;
    localparam int ITEM_UP     = 0;
    localparam int ITEM_LEFT   = 1;
    localparam int ITEM_CORNER = 2;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_GAIN         = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] older;
        logic [PIXEL_BITS-1:0] prev;
    } t_entry;

    typedef struct packed {
        logic [NUM_ITEMS-1:0] has;
        logic                 k1;
        logic                 k2;
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
        logic [LAP_BITS-1:0]  lap1;
        logic [LAP_BITS-1:0]  lap2;
    } t_lap;

    typedef struct packed {
        logic [NUM_ITEMS-1:0]        has;
        logic                        k1;
        logic                        k2;
        logic [COL_BITS-1:0]         col;
        logic [ROW_BITS-1:0]         row;
        logic signed [PROD_BITS-1:0] prod1;
        logic signed [PROD_BITS-1:0] prod2;
    } t_prod;

    typedef struct packed {
        logic [NUM_ITEMS-1:0]  has;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
        logic [VALUE_BITS-1:0] v1;
        logic [VALUE_BITS-1:0] v2;
    } t_bundle;

    typedef struct packed {
        logic [COL_BITS-1:0]   out_col;
        logic [ROW_BITS-1:0]   out_row;
        logic [VALUE_BITS-1:0] value;
        logic                  last_of_run;
        logic                  end_of_frame;
    } t_result;

endpackage

`default_nettype wire

[design/lsf_if.sv]
// Stream interfaces for pixel input beats and filtered result beats.
`default_nettype none

interface lsf_pix_if;
    logic                           valid;
    logic                           ready;
    logic [lsf_pkg::PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lsf_res_if;
    logic                           valid;
    logic                           ready;
    logic [lsf_pkg::COL_BITS-1:0]   out_col;
    logic [lsf_pkg::ROW_BITS-1:0]   out_row;
    logic [lsf_pkg::VALUE_BITS-1:0] value;
    logic                           last_of_run;
    logic                           end_of_frame;

    modport source (output valid, output out_col, output out_row, output value,
                    output last_of_run, output end_of_frame, input ready);
    modport sink   (input valid, input out_col, input out_row, input value,
                    input last_of_run, input end_of_frame, output ready);
endinterface

`default_nettype wire

[design/lsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsf_ram #(
    parameter int DATA_BITS = lsf_pkg::ENTRY_BITS,
    parameter int DEPTH     = lsf_pkg::MAX_WIDTH,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/laplacian_stencil_filter.sv]
// Top level: streaming 3x3 Laplacian filter with two line stores in one RAM.
// A result beat passes registers r_a and r_b, the bundle queue and r_o.
// Throughput: one pixel per cycle unless the result port stalls; on the last row up to three
// results per pixel, so there output paces input to one result beat per cycle.
// Reset (synchronous, active low) clears counters, window, pipeline and registers
// to their defaults; the line-store RAM is not cleared, row 0 of a frame fills it.
`default_nettype none

module laplacian_stencil_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lsf_pix_if.sink                            i_pix,
    lsf_res_if.source                          o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lsf_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lsf_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lsf_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam int PB = lsf_pkg::PIXEL_BITS;
    localparam int LB = lsf_pkg::LAP_BITS;
    localparam int VB = lsf_pkg::VALUE_BITS;
    localparam int CB = lsf_pkg::COL_BITS;
    localparam int RB = lsf_pkg::ROW_BITS;
    localparam int WB = lsf_pkg::WIDTH_BITS;
    localparam int HB = lsf_pkg::HEIGHT_BITS;
    localparam int SB = lsf_pkg::SUM_BITS;
    localparam int FB = lsf_pkg::FRAC_BITS;
    localparam int NI = lsf_pkg::NUM_ITEMS;
    localparam int IB = lsf_pkg::FIFO_IDX_BITS;
    localparam int QB = lsf_pkg::FIFO_PTR_BITS;

    localparam logic [VB-1:0] MID_VALUE = VB'(lsf_pkg::MID_LEVEL);

    function automatic logic [VB-1:0] f_round_sat(
        input logic signed [lsf_pkg::PROD_BITS-1:0] prod
    );
        logic [SB-1:0] sum;
        logic [VB-1:0] res;
        sum = {prod[lsf_pkg::PROD_BITS-1], prod} + SB'(lsf_pkg::ROUND_OFS);
        if (sum[SB-1]) begin
            res = '0;
        end else if (|sum[SB-2:FB+VB]) begin
            res = '1;
        end else begin
            res = sum[FB+VB-1:FB];
        end
        return res;
    endfunction

    // configuration
    logic [WB-1:0]                       r_width;
    logic [HB-1:0]                       r_height;
    logic signed [lsf_pkg::GAIN_BITS-1:0] r_gain;
    logic                                cfg_wr;

    // scan position and window
    logic [CB-1:0] r_col, n_col;
    logic [RB-1:0] r_row, n_row;
    logic [PB-1:0] r_nw0, r_nw1, r_nw2;
    lsf_pkg::t_entry r_cur, r_shadow, n_entry, ram_rd;
    logic [lsf_pkg::ENTRY_BITS-1:0] ram_rd_data;
    logic [lsf_pkg::ADDR_BITS-1:0]  ram_rd_addr;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          last_col, last_row, at_edge, row_one, row_any;
    logic          acc;
    logic [LB-1:0] up, mid, right, above, pix;
    logic [LB-1:0] lap_full, lap_h, lap_v, lap_left;

    // pipeline
    lsf_pkg::t_lap    n_a, r_a;
    lsf_pkg::t_prod   r_b;
    lsf_pkg::t_bundle n_bundle;
    logic             r_a_vld, r_b_vld;

    // bundle queue and unpacker
    lsf_pkg::t_bundle r_fifo [lsf_pkg::FIFO_DEPTH];
    lsf_pkg::t_bundle head;
    logic [QB-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QB-1:0]    r_credit;
    logic [NI-1:0]    r_done, rem, sel;
    logic             nonempty, out_free, pop, emit;
    lsf_pkg::t_result r_o, n_res;
    logic             r_o_vld;

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lsf_pkg::WIDTH_RESET;
            r_height <= lsf_pkg::HEIGHT_RESET;
            r_gain   <= lsf_pkg::GAIN_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                lsf_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[WB-1:0];
                lsf_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[HB-1:0];
                lsf_pkg::REG_GAIN:         r_gain   <= pwdata[lsf_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lsf_pkg::REG_IMAGE_WIDTH:  prdata = lsf_pkg::APB_DATA_BITS'(r_width);
            lsf_pkg::REG_IMAGE_HEIGHT: prdata = lsf_pkg::APB_DATA_BITS'(r_height);
            lsf_pkg::REG_GAIN:         prdata = lsf_pkg::APB_DATA_BITS'(r_gain);
            default:                   prdata = '0;
        endcase
    end

    assign acc         = i_pix.valid & i_pix.ready;
    assign i_pix.ready = (r_credit < QB'(lsf_pkg::FIFO_DEPTH));

    lsf_ram #(
        .DATA_BITS (lsf_pkg::ENTRY_BITS),
        .DEPTH     (lsf_pkg::MAX_WIDTH),
        .ADDR_BITS (lsf_pkg::ADDR_BITS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (acc),
        .i_wr_addr (lsf_pkg::ADDR_BITS'(r_col)),
        .i_wr_data (n_entry),
        .i_rd_en   (acc),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign ram_rd = ram_rd_data;

    always_comb begin
        if (r_width < WB'(lsf_pkg::MIN_SIZE)) begin
            w_eff = WB'(lsf_pkg::MIN_SIZE);
        end else if (r_width > WB'(lsf_pkg::MAX_WIDTH)) begin
            w_eff = WB'(lsf_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < HB'(lsf_pkg::MIN_SIZE)) begin
            h_eff = HB'(lsf_pkg::MIN_SIZE);
        end else if (r_height > HB'(lsf_pkg::MAX_HEIGHT)) begin
            h_eff = HB'(lsf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        last_col = WB'(r_col) >= (w_eff - WB'(1));
        last_row = HB'(r_row) >= (h_eff - HB'(1));
        at_edge  = (r_col == '0) || last_col;
        row_one  = (r_row == RB'(1));
        row_any  = (r_row != '0);

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RB'(1);
        end else begin
            n_col = r_col + CB'(1);
            n_row = r_row;
        end
        ram_rd_addr = lsf_pkg::ADDR_BITS'(n_col + CB'(1));

        n_entry.older = r_cur.prev;
        n_entry.prev  = i_pix.pixel;

        up    = LB'(r_nw0);
        mid   = LB'(r_cur.prev);
        above = LB'(r_cur.older);
        right = LB'(ram_rd.prev);
        pix   = LB'(i_pix.pixel);

        lap_full = up + right + above + pix - (mid << 2);
        lap_h    = up - (mid << 1) + right;
        lap_v    = above - (mid << 1) + pix;
        lap_left = LB'(r_nw2) - (LB'(r_nw1) << 1) + pix;

        n_a.has[lsf_pkg::ITEM_UP]     = row_any;
        n_a.has[lsf_pkg::ITEM_LEFT]   = row_any && last_row && (r_col != '0);
        n_a.has[lsf_pkg::ITEM_CORNER] = row_any && last_row && last_col;
        n_a.k1   = row_one && at_edge;
        n_a.k2   = (r_col == CB'(1));
        n_a.col  = r_col;
        n_a.row  = r_row;
        n_a.lap1 = row_one ? lap_h : (at_edge ? lap_v : lap_full);
        n_a.lap2 = lap_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_nw0 <= '0;
            r_nw1 <= '0;
            r_nw2 <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_nw0 <= r_cur.prev;
            r_nw1 <= i_pix.pixel;
            r_nw2 <= r_nw1;
        end
    end

    // column 0 is shadowed so a new row can start without a second RAM read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (r_col == '0) begin
                r_shadow <= n_entry;
            end
            if (n_col == '0) begin
                r_cur <= (r_col == '0) ? n_entry : r_shadow;
            end else begin
                r_cur <= ram_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b.has   <= r_a.has;
        r_b.k1    <= r_a.k1;
        r_b.k2    <= r_a.k2;
        r_b.col   <= r_a.col;
        r_b.row   <= r_a.row;
        r_b.prod1 <= r_gain * $signed(r_a.lap1);
        r_b.prod2 <= r_gain * $signed(r_a.lap2);
    end

    always_comb begin
        n_bundle.has = r_b.has;
        n_bundle.col = r_b.col;
        n_bundle.row = r_b.row;
        n_bundle.v1  = r_b.k1 ? MID_VALUE : f_round_sat(r_b.prod1);
        n_bundle.v2  = r_b.k2 ? MID_VALUE : f_round_sat(r_b.prod2);
    end

    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_fifo[r_wr_ptr[IB-1:0]] <= n_bundle;
        end
    end

    always_comb begin
        head     = r_fifo[r_rd_ptr[IB-1:0]];
        nonempty = (r_wr_ptr != r_rd_ptr);
        out_free = !r_o_vld || o_res.ready;
        rem      = head.has & ~r_done;
        sel      = rem & (~rem + NI'(1));
        emit     = nonempty && out_free && (rem != '0);
        pop      = nonempty && out_free && ((rem & ~sel) == '0);

        n_res.last_of_run  = ((rem & ~sel) == '0);
        n_res.end_of_frame = 1'b0;
        if (sel[lsf_pkg::ITEM_UP]) begin
            n_res.out_col = head.col;
            n_res.out_row = head.row - RB'(1);
            n_res.value   = head.v1;
        end else if (sel[lsf_pkg::ITEM_LEFT]) begin
            n_res.out_col = head.col - CB'(1);
            n_res.out_row = head.row;
            n_res.value   = head.v2;
        end else begin
            n_res.out_col      = head.col;
            n_res.out_row      = head.row;
            n_res.value        = MID_VALUE;
            n_res.end_of_frame = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_credit <= '0;
            r_done   <= '0;
            r_o_vld  <= 1'b0;
        end else begin
            r_a_vld <= acc;
            r_b_vld <= r_a_vld;
            if (r_b_vld) begin
                r_wr_ptr <= r_wr_ptr + QB'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QB'(1);
                r_done   <= '0;
            end else if (emit) begin
                r_done <= r_done | sel;
            end
            r_credit <= r_credit + QB'(acc) - QB'(pop);
            if (out_free) begin
                r_o_vld <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o <= n_res;
        end
    end

    assign o_res.valid        = r_o_vld;
    assign o_res.out_col      = r_o.out_col;
    assign o_res.out_row      = r_o.out_row;
    assign o_res.value        = r_o.value;
    assign o_res.last_of_run  = r_o.last_of_run;
    assign o_res.end_of_frame = r_o.end_of_frame;

endmodule

`default_nettype wire

[tb/laplacian_stencil_filter_check.sv]
// Checker for the Laplacian stencil filter: predicts filtered beats and compares them.
module laplacian_stencil_filter_check import lsf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lsf_pix_if                       i_pix,
    lsf_res_if                       i_res,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [APB_ADDR_BITS-1:0] i_paddr,
    input  logic [APB_DATA_BITS-1:0] i_pwdata,
    output int                       o_mismatches,
    output int                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int VALUE_MAX    = (1 << VALUE_BITS) - 1;

    logic [WIDTH_BITS-1:0]       width_reg;
    logic [HEIGHT_BITS-1:0]      height_reg;
    logic signed [GAIN_BITS-1:0] gain_reg;

    bit   [PIXEL_BITS-1:0] prev_row  [MAX_WIDTH];
    bit   [PIXEL_BITS-1:0] older_row [MAX_WIDTH];
    logic [COL_BITS-1:0]   col_cnt;
    logic [ROW_BITS-1:0]   row_cnt;
    logic [PIXEL_BITS-1:0] up_left;
    logic [PIXEL_BITS-1:0] left1;
    logic [PIXEL_BITS-1:0] left2;

    t_result pending_filtered[$];
    t_result got;
    t_result want;
    int      mismatches;

    function automatic int clamp_size(int v, int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [VALUE_BITS-1:0] scale_lap(int lap);
        int acc;
        acc = ROUND_OFS + int'(gain_reg) * lap;
        if (acc < 0) return '0;
        acc = acc >>> FRAC_BITS;
        if (acc > VALUE_MAX) return VALUE_BITS'(VALUE_MAX);
        return VALUE_BITS'(acc);
    endfunction

    task automatic add_filtered(int col, int row, logic [VALUE_BITS-1:0] v, logic eof);
        pending_filtered.push_back(t_result'{COL_BITS'(col), ROW_BITS'(row), v, 1'b0, eof});
    endtask

    task automatic filter_pixel(input logic [PIXEL_BITS-1:0] px);
        int w, h, c, r, p, up, mid, right, above;
        bit last_col, last_row, at_side;
        logic [VALUE_BITS-1:0] v;
        w = clamp_size(int'(width_reg), MAX_WIDTH);
        h = clamp_size(int'(height_reg), MAX_HEIGHT);
        c = int'(col_cnt);
        r = int'(row_cnt);
        p = int'(px);
        last_col = c >= w - 1;
        last_row = r >= h - 1;
        if (r >= 1) begin
            up      = int'(up_left);
            mid     = int'(prev_row[c]);
            right   = (c + 1 < MAX_WIDTH) ? int'(prev_row[c + 1]) : 0;
            above   = int'(older_row[c]);
            at_side = (c == 0) || last_col;
            if (r == 1) begin
                v = at_side ? VALUE_BITS'(MID_LEVEL) : scale_lap(up - 2 * mid + right);
            end else if (at_side) begin
                v = scale_lap(above - 2 * mid + p);
            end else begin
                v = scale_lap(up + right + above + p - 4 * mid);
            end
            add_filtered(c, r - 1, v, 1'b0);
            if (last_row) begin
                if (c >= 1) begin
                    v = (c == 1) ? VALUE_BITS'(MID_LEVEL)
                                 : scale_lap(int'(left2) - 2 * int'(left1) + p);
                    add_filtered(c - 1, r, v, 1'b0);
                end
                if (last_col) add_filtered(c, r, VALUE_BITS'(MID_LEVEL), 1'b1);
            end
            pending_filtered[$].last_of_run = 1'b1;
        end
        up_left      = prev_row[c];
        left2        = left1;
        left1        = px;
        older_row[c] = prev_row[c];
        prev_row[c]  = px;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : ROW_BITS'(r + 1);
        end else begin
            col_cnt = COL_BITS'(c + 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            gain_reg   = GAIN_RESET;
            col_cnt    = '0;
            row_cnt    = '0;
            up_left    = '0;
            left1      = '0;
            left2      = '0;
            pending_filtered.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_BITS-1:2])
                    REG_IMAGE_WIDTH:  width_reg  = i_pwdata[WIDTH_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg = i_pwdata[HEIGHT_BITS-1:0];
                    REG_GAIN:         gain_reg   = i_pwdata[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) filter_pixel(i_pix.pixel);
            if (i_res.valid && i_res.ready) begin
                got = t_result'{i_res.out_col, i_res.out_row, i_res.value,
                                i_res.last_of_run, i_res.end_of_frame};
                if (pending_filtered.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result beat: col %0d row %0d value %0d",
                                 got.out_col, got.out_row, got.value);
                end else begin
                    want = pending_filtered.pop_front();
                    if (got.out_col !== want.out_col || got.out_row !== want.out_row ||
                        got.value !== want.value || got.last_of_run !== want.last_of_run ||
                        got.end_of_frame !== want.end_of_frame) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result error: expected col %0d row %0d value %0d ",
                                      "last %0b eof %0b, got col %0d row %0d value %0d ",
                                      "last %0b eof %0b"},
                                     want.out_col, want.out_row, want.value,
                                     want.last_of_run, want.end_of_frame,
                                     got.out_col, got.out_row, got.value,
                                     got.last_of_run, got.end_of_frame);
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_filtered.size();
    end

endmodule

[tb/laplacian_stencil_filter_test.sv]
// Testbench top for the Laplacian stencil filter: pixel frames, register writes, verdict.
module laplacian_stencil_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsf_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_ITEMS   = 120;
    localparam int GAIN_MIN      = -(1 << (GAIN_BITS - 1));
    localparam int GAIN_MAX      = (1 << (GAIN_BITS - 1)) - 1;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [9*PIXEL_BITS-1:0] TIE_FRAME =
        {8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd3, 8'd250, 8'd64};

    typedef enum int {FILL_NOISE, FILL_FLAT, FILL_BINARY, FILL_RAMP} t_fill;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_served;
    int pixels_sent;
    int quiet_cycles;
    int mismatches;
    int outstanding;

    lsf_pix_if pix_if ();
    lsf_res_if res_if ();

    laplacian_stencil_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    laplacian_stencil_filter_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix_if),
        .i_res         (res_if),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("laplacian_stencil_filter: mismatch");
            $finish;
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                holds_served++;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic int clamp_size(int v, int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(t_fill fill, int col, int row,
                                                         logic [PIXEL_BITS-1:0] base);
        case (fill)
            FILL_FLAT:   return base;
            FILL_BINARY: return $urandom_range(0, 1) ? '1 : '0;
            FILL_RAMP:   return PIXEL_BITS'(int'(base) + col * 9 + row * 5);
            default:     return PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [WIDTH_BITS-1:0] w, input logic [HEIGHT_BITS-1:0] h,
                             input logic [GAIN_BITS-1:0] g);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, APB_DATA_BITS'(w));
        write_reg(REG_IMAGE_HEIGHT, APB_DATA_BITS'(h));
        write_reg(REG_GAIN, APB_DATA_BITS'(g));
    endtask

    task automatic send_frame(int cols, int rows, t_fill fill);
        logic [PIXEL_BITS-1:0] base;
        base = PIXEL_BITS'($urandom);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) send_pixel(pick_pixel(fill, c, r, base));
        end
    endtask

    task automatic random_frame();
        logic [WIDTH_BITS-1:0]  w;
        logic [HEIGHT_BITS-1:0] h;
        logic [GAIN_BITS-1:0]   g;
        w = WIDTH_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 12));
        h = HEIGHT_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 8));
        case ($urandom_range(0, 5))
            0:       g = GAIN_BITS'(GAIN_MIN);
            1:       g = GAIN_BITS'(GAIN_MAX);
            2:       g = GAIN_BITS'(256);
            3:       g = GAIN_BITS'(128);
            4:       g = GAIN_BITS'(int'($urandom_range(0, 2047)) - 1024);
            default: g = GAIN_BITS'($urandom);
        endcase
        configure(w, h, g);
        send_frame(clamp_size(int'(w), MAX_WIDTH), clamp_size(int'(h), MAX_HEIGHT),
                   t_fill'($urandom_range(0, 3)));
    endtask

    initial begin
        int start;
        pix_if.valid  = 1'b0;
        pix_if.pixel  = '0;
        send_idle_pct = 20;
        recv_idle_pct = 45;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // undersized frame clamps to 3x3, write to an unused address, half gain for ties
        configure(0, 2, GAIN_BITS'(128));
        write_reg(REG_SPARE, APB_DATA_BITS'(32'h0000_00ff));
        for (int k = 8; k >= 0; k--) send_pixel(TIE_FRAME[k*PIXEL_BITS +: PIXEL_BITS]);

        // shrink the frame while inside row 2, column 2
        configure(5, 4, GAIN_BITS'(GAIN_MAX));
        for (int k = 0; k < 12; k++) send_pixel(PIXEL_BITS'(k * 73 + 11));
        configure(3, 3, GAIN_BITS'(GAIN_MIN));
        send_pixel('1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 45 : 0;
            recv_idle_pct <= (phase == 0) ? 45 : (phase == 1) ? 20 : 0;
            start = pixels_sent;
            if (phase == 0) begin
                configure(12, 8, GAIN_BITS'(256));
                hold_requests <= hold_requests + 1;
                send_frame(12, 8, FILL_NOISE);
            end
            while (pixels_sent - start < PHASE_ITEMS) random_frame();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("laplacian_stencil_filter: match");
        end else begin
            $display("laplacian_stencil_filter: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
design/lsf_pkg.sv
design/lsf_if.sv
design/lsf_ram.sv
design/laplacian_stencil_filter.sv
tb/laplacian_stencil_filter_check.sv
tb/laplacian_stencil_filter_test.sv
